>>> hw/rtl/msp_pkg.sv
// Shared constants, codes and types of the multiplexed servo pulse generator.
package msp_pkg;

	// Channel count, stored width size and counter sizes.
	localparam int CHANNELS   = 8;
	localparam int WIDTH_BITS = 12;
	localparam int POS_BITS   = 12;
	localparam int IDX_BITS   = 3;
	localparam int LINE_BITS  = 8;

	// Reset values of the slot length and of every stored width.
	localparam logic [POS_BITS-1:0]   SLOT_RESET  = POS_BITS'(2500);
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(1500);

	// Kinds of input request.
	typedef enum logic {
		MODE_TICK = 1'b0,
		MODE_SET  = 1'b1
	} mode_t;

	// One input request as seen by the timing core.
	typedef struct packed {
		logic [0:0]            mode;
		logic [IDX_BITS-1:0]   channel;
		logic [WIDTH_BITS-1:0] width_us;
	} msp_item_t;

	// One result as produced by the timing core.
	typedef struct packed {
		logic [LINE_BITS-1:0] servo_lines;
		logic [IDX_BITS-1:0]  active_slot;
	} msp_result_t;

endpackage

>>> hw/rtl/msp_core.sv
// Slot timing core: width store, slot counters and line level decode.
module msp_core import msp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_fire,
	input  msp_item_t           item,
	input  logic                cfg_fire,
	input  logic [POS_BITS-1:0] cfg_data,
	output msp_result_t         result
);

	logic [WIDTH_BITS-1:0] width_store_q [CHANNELS];
	logic [POS_BITS-1:0]   slot_len_q;
	logic [POS_BITS-1:0]   slot_pos_q;
	logic [IDX_BITS-1:0]   slot_idx_q;
	logic [POS_BITS-1:0]   latched_q;

	logic [POS_BITS:0]     next_pos;
	logic                  slot_end;
	logic [IDX_BITS-1:0]   next_idx;
	logic [WIDTH_BITS-1:0] next_entry;
	logic [POS_BITS-1:0]   next_latched;
	logic                  line_high;
	logic                  is_set;

	assign is_set = (item.mode == MODE_SET);

	// Position advance and end of slot detection.
	assign next_pos = {1'b0, slot_pos_q} + (POS_BITS+1)'(1);
	assign slot_end = (next_pos >= {1'b0, slot_len_q});

	// Next slot index, wrapping after the last channel.
	always_comb begin
		if (slot_idx_q == IDX_BITS'(CHANNELS - 1)) begin
			next_idx = '0;
		end else begin
			next_idx = slot_idx_q + IDX_BITS'(1);
		end
	end

	// Width of the next channel, saturated to the slot length.
	assign next_entry   = width_store_q[next_idx];
	assign next_latched = (POS_BITS'(next_entry) > slot_len_q) ? slot_len_q
	                                                           : POS_BITS'(next_entry);

	// The running channel's line is high while the position is below both limits.
	assign line_high = (slot_pos_q < latched_q) && (slot_pos_q < slot_len_q);

	always_comb begin
		result.active_slot = slot_idx_q;
		if (line_high) begin
			result.servo_lines = LINE_BITS'(1) << slot_idx_q;
		end else begin
			result.servo_lines = '0;
		end
	end

	// Slot length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_len_q <= SLOT_RESET;
		end else if (cfg_fire) begin
			slot_len_q <= cfg_data;
		end
	end

	// Width store, written by set requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				width_store_q[k] <= WIDTH_RESET;
			end
		end else if (item_fire && is_set && (int'(item.channel) < CHANNELS)) begin
			width_store_q[item.channel] <= item.width_us;
		end
	end

	// Slot counters and latched width, advanced by tick requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_pos_q <= '0;
			slot_idx_q <= '0;
			latched_q  <= (POS_BITS'(WIDTH_RESET) > SLOT_RESET) ? SLOT_RESET
			                                                     : POS_BITS'(WIDTH_RESET);
		end else if (item_fire && !is_set) begin
			if (slot_end) begin
				slot_pos_q <= '0;
				slot_idx_q <= next_idx;
				latched_q  <= next_latched;
			end else begin
				slot_pos_q <= next_pos[POS_BITS-1:0];
			end
		end
	end

	// A set request leaves the slot timing untouched.
	a_set_keeps_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && is_set |=> $stable(slot_pos_q) && $stable(slot_idx_q))
		else $error("set request moved the slot timing");

	// A tick that ends a slot restarts the position at zero.
	a_slot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && !is_set && slot_end |=> slot_pos_q == '0)
		else $error("slot did not restart after its end");

	// At most one servo line is ever high.
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(result.servo_lines))
		else $error("more than one servo line high");

	// Only the running slot's line may be high.
	a_line_matches_slot: assert property (@(posedge clk) disable iff (!arst_n)
		result.servo_lines != '0 |-> result.servo_lines[slot_idx_q])
		else $error("servo line high outside its slot");

endmodule

>>> hw/rtl/multiplexed_servo_pulse_generator.sv
// Top level of the multiplexed servo pulse generator with its result register.
// The block takes one request per clock cycle, a tick or a width write, and
// returns exactly one result per request in the cycle after it, through a result
// register: the eight servo line levels and the running slot, as they stood
// before that request took effect. A new request is taken in the same cycle
// in which the previous result is taken, so the sustained rate is one request
// per cycle; only a stall on the result side holds the input. The slot length
// register is written through its own channel, which is always ready.
module multiplexed_servo_pulse_generator import msp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [0:0]            mode,
	input  logic [IDX_BITS-1:0]   channel,
	input  logic [WIDTH_BITS-1:0] width_us,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LINE_BITS-1:0]  servo_lines,
	output logic [IDX_BITS-1:0]   active_slot,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [POS_BITS-1:0]   cfg_data
);

	msp_item_t   item;
	msp_result_t result;
	msp_result_t result_q;
	logic        out_valid_q;
	logic        in_fire;
	logic        cfg_fire;

	// Request handshakes.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign item.mode     = mode;
	assign item.channel  = channel;
	assign item.width_us = width_us;

	msp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (in_fire),
		.item      (item),
		.cfg_fire  (cfg_fire),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with each accepted request.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			result_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign servo_lines = result_q.servo_lines;
	assign active_slot = result_q.active_slot;

endmodule

>>> dv/tb_multiplexed_servo_pulse_generator.sv
// Self-checking testbench for the multiplexed servo pulse generator, with its own slot timing model.
module tb_multiplexed_servo_pulse_generator;
	import msp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// Clock, reset and block ports.
	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [0:0]            mode      = MODE_TICK;
	logic [IDX_BITS-1:0]   channel   = '0;
	logic [WIDTH_BITS-1:0] width_us  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [LINE_BITS-1:0]  servo_lines;
	logic [IDX_BITS-1:0]   active_slot;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [POS_BITS-1:0]   cfg_data  = '0;

	// Timing model state: stored widths, slot counters and slot length.
	logic [WIDTH_BITS-1:0] width_mem [CHANNELS];
	logic [POS_BITS-1:0]   slot_len;
	logic [POS_BITS-1:0]   pos_now;
	logic [IDX_BITS-1:0]   slot_now;
	logic [POS_BITS-1:0]   held_width;

	// Line levels still to come out of the block, oldest first.
	msp_result_t levels_due [$];

	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int stall_goal     = 0;
	int stall_left     = 0;
	int cycle_count    = 0;

	multiplexed_servo_pulse_generator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.channel    (channel),
		.width_us   (width_us),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.servo_lines(servo_lines),
		.active_slot(active_slot),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: the run is abandoned once the cycle count reaches its limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_multiplexed_servo_pulse_generator NOT OK");
		$finish;
	end

	// Prints one line per mismatch and keeps the count.
	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Reports the line levels of the current microsecond, then applies the request.
	function automatic msp_result_t servo_timing_step(mode_t kind, logic [IDX_BITS-1:0] ch,
			logic [WIDTH_BITS-1:0] w);
		msp_result_t          r;
		logic [POS_BITS:0]    nxt;
		logic [WIDTH_BITS-1:0] fresh;
		r.servo_lines = '0;
		if (pos_now < held_width && pos_now < slot_len) begin
			r.servo_lines[slot_now] = 1'b1;
		end
		r.active_slot = slot_now;
		if (kind == MODE_SET) begin
			width_mem[ch] = w;
		end else begin
			nxt = {1'b0, pos_now} + 1'b1;
			if (nxt >= {1'b0, slot_len}) begin
				// End of slot: move to the next channel and latch its width.
				pos_now  = '0;
				slot_now = (slot_now == IDX_BITS'(CHANNELS - 1)) ? '0 : slot_now + 1'b1;
				fresh    = width_mem[slot_now];
				held_width = (fresh > slot_len) ? slot_len : fresh;
			end else begin
				pos_now = nxt[POS_BITS-1:0];
			end
		end
		return r;
	endfunction

	// Model reset, then track accepted configuration writes and requests.
	initial begin
		for (int k = 0; k < CHANNELS; k++) width_mem[k] = WIDTH_RESET;
		slot_len   = SLOT_RESET;
		pos_now    = '0;
		slot_now   = '0;
		held_width = (WIDTH_RESET > SLOT_RESET) ? SLOT_RESET : WIDTH_RESET;
	end

	always @(posedge clk) begin
		msp_result_t want;
		// Compare every accepted result with the oldest prediction.
		if (arst_n && out_valid && out_ready) begin
			if (levels_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing due: lines %0h slot %0d",
					servo_lines, active_slot));
			end else begin
				want = levels_due.pop_front();
				if (servo_lines !== want.servo_lines)
					report_mismatch($sformatf("servo_lines got %0h, expected %0h",
						servo_lines, want.servo_lines));
				if (active_slot !== want.active_slot)
					report_mismatch($sformatf("active_slot got %0d, expected %0d",
						active_slot, want.active_slot));
			end
		end
		// Follow the slot length register and every accepted request.
		if (arst_n && cfg_valid && cfg_ready) slot_len = cfg_data;
		if (arst_n && in_valid && in_ready)
			levels_due.push_back(servo_timing_step(mode_t'(mode), channel, width_us));
	end

	// Receiver: random stalls, and a long hold-off when one is asked for.
	always @(posedge clk) begin
		if (stall_goal > 0) begin
			stall_left = stall_goal;
			stall_goal = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one request after a random gap and waits until it is taken.
	task automatic send_request(input mode_t kind, input logic [IDX_BITS-1:0] ch,
			input logic [WIDTH_BITS-1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= kind;
		channel  <= ch;
		width_us <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops offering requests and waits until every predicted result has come.
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (levels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the slot length while the block is idle.
	task automatic write_slot_length(input logic [POS_BITS-1:0] value);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Timing straight after reset, with the reset slot length and widths.
	task automatic test_reset_state();
		repeat (3) send_request(MODE_TICK, '0, '0);
		send_request(MODE_SET, 3'd7, 12'hfff);
		send_request(MODE_SET, 3'd0, 12'h000);
		send_request(MODE_TICK, 3'd7, 12'hfff);
	endtask

	// Shortest, empty and longest slots.
	task automatic test_slot_length_extremes();
		write_slot_length(12'd1);
		repeat (3) send_request(MODE_TICK, '0, '0);
		write_slot_length(12'd0);
		repeat (2) send_request(MODE_TICK, '0, '0);
		write_slot_length(12'hfff);
		repeat (2) send_request(MODE_TICK, '0, '0);
	endtask

	// Zero width, width equal to the slot and width saturated to the slot.
	task automatic test_width_edges();
		write_slot_length(12'd3);
		send_request(MODE_SET, 3'd1, 12'd0);
		send_request(MODE_SET, 3'd2, 12'd3);
		send_request(MODE_SET, 3'd3, 12'hfff);
		send_request(MODE_SET, 3'd4, 12'd1);
		repeat (9) send_request(MODE_TICK, '0, '0);
	endtask

	// Slot length lowered part-way through a slot.
	task automatic test_slot_shortened();
		write_slot_length(12'd8);
		repeat (4) send_request(MODE_TICK, '0, '0);
		write_slot_length(12'd2);
		repeat (3) send_request(MODE_TICK, '0, '0);
	endtask

	// Random requests under one idling pattern, with a new slot length now and then.
	task automatic test_random_traffic(input int count, input int slot_lo, input int slot_hi,
			input int send_pct, input int recv_pct);
		int    slot;
		int    top;
		mode_t kind;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		slot = slot_lo;
		for (int k = 0; k < count; k++) begin
			if (k % 90 == 0) begin
				slot = $urandom_range(slot_hi, slot_lo);
				write_slot_length(POS_BITS'(slot));
			end
			// Mostly ticks, so that the frame keeps turning over.
			kind = ($urandom_range(99) < 25) ? MODE_SET : MODE_TICK;
			top  = (slot + 2 > 4095) ? 4095 : slot + 2;
			send_request(kind, IDX_BITS'($urandom_range(CHANNELS - 1)),
				WIDTH_BITS'(($urandom_range(3) == 0) ? $urandom_range(4095)
				                                     : $urandom_range(top)));
		end
	endtask

	// A long receiver hold-off while the sender keeps offering requests.
	task automatic test_back_pressure();
		write_slot_length(12'd5);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		stall_goal     = 300;
		for (int k = 0; k < 60; k++) begin
			send_request(($urandom_range(3) == 0) ? MODE_SET : MODE_TICK,
				IDX_BITS'($urandom_range(CHANNELS - 1)), WIDTH_BITS'($urandom_range(7)));
		end
	endtask

	// Test sequence.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_slot_length_extremes();
		test_width_edges();
		test_slot_shortened();
		test_random_traffic(270, 1, 12, 0, 0);
		test_random_traffic(270, 1, 30, 51, 0);
		test_random_traffic(270, 2, 20, 0, 51);
		test_random_traffic(270, 1, 40, 21, 21);
		test_back_pressure();
		settle_idle();
		repeat (8) @(posedge clk);
		if (levels_due.size() != 0)
			report_mismatch($sformatf("%0d results never came", levels_due.size()));
		if (error_count == 0) begin
			$display("tb_multiplexed_servo_pulse_generator OK");
		end else begin
			$display("tb_multiplexed_servo_pulse_generator NOT OK");
		end
		$finish;
	end

endmodule
